### rtl/core/smpq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted max priority queue package
// Request and status codes, cell commands and the link between cells.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int ValueW = 64;
    localparam int CountW = 7;

    localparam logic [2:0] REQ_PUSH  = 3'd0;
    localparam logic [2:0] REQ_PEEK  = 3'd1;
    localparam logic [2:0] REQ_POP   = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_PUSH   = 3'd1,
        CELL_POP    = 3'd2,
        CELL_ROTATE = 3'd3,
        CELL_CLEAR  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [ValueW-1:0]   push_value;
        logic [ValueW-1:0]   head_value;
    } cell_cmd_t;

    typedef struct packed {
        logic [ValueW-1:0]   value;
        logic                valid;
        logic                gt;
    } cell_link_t;

endpackage

### rtl/core/sorted_max_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted max priority queue unit
// Keeps up to DEPTH 64-bit values sorted from largest to smallest in a chain.
// ----------------------------------------------------------------------------
// Each entry lives in one cell of a chain; a push, pop, peek or clear is carried
// out by all cells together, so with the result side ready and no read-all under
// way these requests are taken one beat per cycle. A read-all streams the entries
// largest first, one beat per cycle while the result side is ready, by rotating
// the valid part of the chain through its head cell; it refuses new requests until
// its last beat is issued and leaves the order as it was. Results go out in request
// order, and the last beat of each request carries tlast.
module sorted_max_priority_queue_unit #(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] result_value, [70:64] count, zero pad
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                remain_reg, remain_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [smpq_pkg::ValueW-1:0]  result_reg, result_next;
    logic [1:0]                   status_reg, status_next;
    logic [CW-1:0]                rcount_reg, rcount_next;
    logic                         last_reg, last_next;

    smpq_pkg::cell_cmd_t          cmd;
    smpq_pkg::cell_link_t         links [DEPTH];
    logic [DEPTH-1:0]             valid_vec;
    logic                         out_free;
    logic                         accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            smpq_pkg::cell_link_t left_l;
            smpq_pkg::cell_link_t right_l;
            if (g == 0) begin : g_first
                assign left_l = '{value: '0, valid: 1'b0, gt: 1'b1};
            end else begin : g_mid
                assign left_l = links[g-1];
            end
            if (g == DEPTH - 1) begin : g_end
                assign right_l = '{value: '0, valid: 1'b0, gt: 1'b0};
            end else begin : g_inner
                assign right_l = links[g+1];
            end
            smpq_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd),
                .left    (left_l),
                .right   (right_l),
                .self    (links[g])
            );
            assign valid_vec[g] = links[g].valid;
        end
    endgenerate

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        result_next    = result_reg;
        status_next    = status_reg;
        rcount_next    = rcount_reg;
        last_next      = last_reg;
        cmd.op         = smpq_pkg::CELL_HOLD;
        cmd.push_value = s_tdata;
        cmd.head_value = links[0].value;

        if (accept) begin
            m_tvalid_next = 1'b1;
            result_next   = '0;
            status_next   = smpq_pkg::STATUS_OK;
            rcount_next   = count_reg;
            last_next     = 1'b1;
            case (s_tuser)
                smpq_pkg::REQ_PUSH: begin
                    if (count_reg == CW'(DEPTH)) begin
                        status_next = smpq_pkg::STATUS_FULL;
                    end else begin
                        cmd.op      = smpq_pkg::CELL_PUSH;
                        count_next  = count_reg + 1'b1;
                        rcount_next = count_reg + 1'b1;
                    end
                end
                smpq_pkg::REQ_PEEK: begin
                    if (count_reg == '0) begin
                        status_next = smpq_pkg::STATUS_EMPTY;
                    end else begin
                        result_next = links[0].value;
                    end
                end
                smpq_pkg::REQ_POP: begin
                    if (count_reg == '0) begin
                        status_next = smpq_pkg::STATUS_EMPTY;
                    end else begin
                        cmd.op      = smpq_pkg::CELL_POP;
                        result_next = links[0].value;
                        count_next  = count_reg - 1'b1;
                        rcount_next = count_reg - 1'b1;
                    end
                end
                smpq_pkg::REQ_READ: begin
                    if (count_reg == '0) begin
                        status_next = smpq_pkg::STATUS_EMPTY;
                    end else begin
                        m_tvalid_next = 1'b0;
                        remain_next   = count_reg;
                        state_next    = ST_READ;
                    end
                end
                smpq_pkg::REQ_CLEAR: begin
                    cmd.op      = smpq_pkg::CELL_CLEAR;
                    count_next  = '0;
                    rcount_next = '0;
                end
                default: begin
                    status_next = smpq_pkg::STATUS_OK;
                end
            endcase
        end else if (state_reg == ST_READ && out_free) begin
            cmd.op        = smpq_pkg::CELL_ROTATE;
            m_tvalid_next = 1'b1;
            result_next   = links[0].value;
            status_next   = smpq_pkg::STATUS_OK;
            rcount_next   = count_reg;
            last_next     = (remain_reg == CW'(1));
            remain_next   = remain_reg - 1'b1;
            if (remain_reg == CW'(1)) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            remain_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            remain_reg   <= remain_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        status_reg <= status_next;
        rcount_reg <= rcount_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, smpq_pkg::CountW'(rcount_reg), result_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("Entry count disagrees with the valid cells.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("Entry count exceeds the depth.");

    a_open_beat_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !last_reg |-> state_reg == ST_READ)
        else $error("A beat without tlast appeared outside a read-out.");

    a_read_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> $stable(count_reg))
        else $error("Entry count changed during a read-out.");

endmodule

### rtl/core/smpq_cell.sv
// ----------------------------------------------------------------------------
// Sorted max priority queue cell
// Holds one entry of the sorted chain and moves it toward either neighbor.
// ----------------------------------------------------------------------------
module smpq_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  smpq_pkg::cell_cmd_t   cmd,
    input  smpq_pkg::cell_link_t  left,
    input  smpq_pkg::cell_link_t  right,
    output smpq_pkg::cell_link_t  self
);

    logic [smpq_pkg::ValueW-1:0] value_reg;
    logic [smpq_pkg::ValueW-1:0] value_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        gt;

    assign gt = valid_reg && (value_reg > cmd.push_value);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (cmd.op)
            smpq_pkg::CELL_PUSH: begin
                if (!gt) begin
                    if (left.gt) begin
                        value_next = cmd.push_value;
                        valid_next = 1'b1;
                    end else begin
                        value_next = left.value;
                        valid_next = left.valid;
                    end
                end
            end
            smpq_pkg::CELL_POP: begin
                value_next = right.value;
                valid_next = right.valid;
            end
            smpq_pkg::CELL_ROTATE: begin
                if (right.valid) begin
                    value_next = right.value;
                end else if (valid_reg) begin
                    value_next = cmd.head_value;
                end
            end
            smpq_pkg::CELL_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign self.value = value_reg;
    assign self.valid = valid_reg;
    assign self.gt    = gt;

endmodule

### tb/sorted_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted queue result checker
// Watches both streams of the sorted max priority queue, keeps a shadow copy
// of the sorted store, and compares every result beat field by field with the
// oldest beat predicted from the accepted requests.
// ----------------------------------------------------------------------------
module sorted_queue_checker #(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [63:0] result_value, [70:64] count, zero pad
    input  logic [1:0]  m_tuser,   // [1:0] status
    input  logic        m_tlast,
    output int          errors,
    output int          pending,
    output int          beats,
    output int          full_refusals,
    output int          empty_reports
);

    typedef struct packed {
        logic [smpq_pkg::ValueW-1:0] value;
        logic [1:0]                  status;
        logic [smpq_pkg::CountW-1:0] count;
        logic                        last;
    } result_beat_t;

    logic [smpq_pkg::ValueW-1:0] shadow_entries [DEPTH];
    int                          shadow_count;
    result_beat_t                expected_beats [$];

    task automatic queue_beat(input logic [smpq_pkg::ValueW-1:0] v, input logic [1:0] st,
                              input int cnt, input logic lst);
        result_beat_t b;
        b.value  = v;
        b.status = st;
        b.count  = smpq_pkg::CountW'(cnt);
        b.last   = lst;
        expected_beats.push_back(b);
        if (st == smpq_pkg::STATUS_FULL) full_refusals++;
        if (st == smpq_pkg::STATUS_EMPTY) empty_reports++;
    endtask

    task automatic apply_request(input logic [2:0] req,
                                 input logic [smpq_pkg::ValueW-1:0] v);
        int pos;
        int i;
        case (req)
            smpq_pkg::REQ_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    queue_beat('0, smpq_pkg::STATUS_FULL, shadow_count, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < shadow_count && shadow_entries[pos] > v) pos++;
                    for (i = shadow_count; i > pos; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = v;
                    shadow_count++;
                    queue_beat('0, smpq_pkg::STATUS_OK, shadow_count, 1'b1);
                end
            end
            smpq_pkg::REQ_PEEK: begin
                if (shadow_count == 0)
                    queue_beat('0, smpq_pkg::STATUS_EMPTY, 0, 1'b1);
                else
                    queue_beat(shadow_entries[0], smpq_pkg::STATUS_OK, shadow_count, 1'b1);
            end
            smpq_pkg::REQ_POP: begin
                if (shadow_count == 0) begin
                    queue_beat('0, smpq_pkg::STATUS_EMPTY, 0, 1'b1);
                end else begin
                    queue_beat(shadow_entries[0], smpq_pkg::STATUS_OK, shadow_count - 1,
                               1'b1);
                    for (i = 0; i < shadow_count - 1; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
            smpq_pkg::REQ_READ: begin
                if (shadow_count == 0) begin
                    queue_beat('0, smpq_pkg::STATUS_EMPTY, 0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_count; i++)
                        queue_beat(shadow_entries[i], smpq_pkg::STATUS_OK, shadow_count,
                                   i == shadow_count - 1);
                end
            end
            smpq_pkg::REQ_CLEAR: begin
                shadow_count = 0;
                queue_beat('0, smpq_pkg::STATUS_OK, 0, 1'b1);
            end
            default: queue_beat('0, smpq_pkg::STATUS_OK, shadow_count, 1'b1);
        endcase
    endtask

    task automatic compare_field(input string fname, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch on beat %0d: expected %h, got %h",
                     $time, fname, beats, want, got);
        end
    endtask

    initial begin
        errors        = 0;
        pending       = 0;
        beats         = 0;
        full_refusals = 0;
        empty_reports = 0;
        shadow_count  = 0;
    end

    always @(posedge aclk) begin
        result_beat_t want;
        if (!aresetn) begin
            shadow_count = 0;
            expected_beats.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                beats++;
                if (expected_beats.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected beat: expected none, got value %h status %0d",
                             $time, m_tdata[63:0], m_tuser);
                end else begin
                    want = expected_beats.pop_front();
                    compare_field("result_value", want.value, m_tdata[63:0]);
                    compare_field("count", 64'(want.count), 64'(m_tdata[70:64]));
                    compare_field("status", 64'(want.status), 64'(m_tuser));
                    compare_field("last", 64'(want.last), 64'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata);
        end
        pending = expected_beats.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted max priority queue testbench
// Drives directed and random requests into the queue with random gaps on both
// streams, a long result-side hold-off that stalls the input, a fill of the
// store past capacity, and a drain pause; the checker predicts and compares
// every result beat.
// ----------------------------------------------------------------------------
module tb;

    localparam int         DEPTH       = 64;
    localparam logic [2:0] REQ_RSVD_LO = 3'd5;
    localparam logic [2:0] REQ_RSVD_HI = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int errors;
    int pending;
    int beats;
    int full_refusals;
    int empty_reports;
    int sent;
    bit steady;
    bit hold_rx;

    sorted_max_priority_queue_unit #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sorted_queue_checker #(.DEPTH(DEPTH)) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .errors        (errors),
        .pending       (pending),
        .beats         (beats),
        .full_refusals (full_refusals),
        .empty_reports (empty_reports)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Small pools and the two extremes make equal values common.
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return {2'($urandom_range(0, 3)), 59'd0, 3'($urandom_range(0, 7))};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_request(input logic [2:0] req, input logic [63:0] v);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (!steady && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      send_request(smpq_pkg::REQ_PUSH, pick_value());
        else if (r < 70) send_request(smpq_pkg::REQ_POP, {$urandom, $urandom});
        else if (r < 80) send_request(smpq_pkg::REQ_PEEK, {$urandom, $urandom});
        else if (r < 88) send_request(smpq_pkg::REQ_READ, {$urandom, $urandom});
        else if (r < 92) send_request(smpq_pkg::REQ_CLEAR, {$urandom, $urandom});
        else send_request(3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI)), {$urandom, $urandom});
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, or a long counted hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_rx = 1'b0;
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 14);
            @(posedge aclk);
        end
    end

    initial begin
        int k;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = smpq_pkg::REQ_PUSH;
        sent     = 0;
        steady   = 1'b0;
        hold_rx  = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(smpq_pkg::REQ_PEEK, '1);
        send_request(smpq_pkg::REQ_POP, '0);
        send_request(smpq_pkg::REQ_READ, {$urandom, $urandom});
        send_request(smpq_pkg::REQ_CLEAR, '1);
        send_request(REQ_RSVD_LO, {$urandom, $urandom});
        send_request(smpq_pkg::REQ_PUSH, '1);
        send_request(smpq_pkg::REQ_PUSH, '0);
        send_request(smpq_pkg::REQ_PUSH, 64'h5);
        send_request(smpq_pkg::REQ_PUSH, 64'h5);
        send_request(smpq_pkg::REQ_PUSH, 64'h8000_0000_0000_0000);
        send_request(smpq_pkg::REQ_PEEK, '0);
        send_request(smpq_pkg::REQ_READ, '1);
        send_request(smpq_pkg::REQ_POP, '1);
        send_request(smpq_pkg::REQ_POP, '0);
        send_request(REQ_RSVD_LO + 3'd1, '1);
        send_request(REQ_RSVD_HI, '1);
        send_request(smpq_pkg::REQ_READ, '0);
        send_request(smpq_pkg::REQ_CLEAR, '0);
        send_request(smpq_pkg::REQ_READ, '0);
        send_request(smpq_pkg::REQ_PUSH, {$urandom, $urandom});
        send_request(smpq_pkg::REQ_POP, '0);
        send_request(smpq_pkg::REQ_POP, '0);

        // Hold the result side off so the input stalls, then fill the store past capacity.
        hold_rx = 1'b1;
        send_request(smpq_pkg::REQ_CLEAR, {$urandom, $urandom});
        repeat (DEPTH) send_request(smpq_pkg::REQ_PUSH, pick_value());
        send_request(smpq_pkg::REQ_PUSH, '1);
        send_request(smpq_pkg::REQ_PUSH, '0);
        send_request(smpq_pkg::REQ_PEEK, '0);
        send_request(smpq_pkg::REQ_READ, '0);
        wait_for_drain();
        repeat (5) send_request(smpq_pkg::REQ_POP, '0);
        send_request(smpq_pkg::REQ_READ, '0);

        steady = 1'b1;
        repeat (30) send_random_request();
        steady = 1'b0;

        while (sent < 270) send_random_request();

        s_tvalid <= 1'b0;
        k = 0;
        while (pending != 0 && k < 200_000) begin
            @(posedge aclk);
            k++;
        end
        repeat (70) @(posedge aclk);

        $display("Sent %0d requests and checked %0d result beats.", sent, beats);
        $display("Results reporting a full store: %0d, an empty store: %0d.",
                 full_refusals, empty_reports);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/smpq_pkg.sv
rtl/core/smpq_cell.sv
rtl/core/sorted_max_priority_queue_unit.sv
tb/sorted_queue_checker.sv
tb/tb.sv
